### sv/wht_pkg.sv
package wht_pkg;

   localparam int X_BITS = 12;
   localparam int Y_BITS = 11;
   localparam int ID_BITS = 4;
   localparam int WINDOWS_DEFAULT = 16;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CLICK = 1'b1;

   typedef struct packed {
      logic [X_BITS-1:0] left;
      logic [Y_BITS-1:0] bottom;
      logic [X_BITS-1:0] right;
      logic [Y_BITS-1:0] top;
   } rect_type;

   // one slot of the stacking order: the window and its rectangle travel together
   typedef struct packed {
      logic               valid;
      logic [ID_BITS-1:0] id;
      rect_type           rect;
   } entry_type;

   // operands broadcast to every cell when a transaction is taken
   typedef struct packed {
      logic               command;
      logic [ID_BITS-1:0] idx;
      logic [X_BITS-1:0]  x;
      logic [Y_BITS-1:0]  y;
   } op_type;

   typedef struct packed {
      logic advance;
      logic load;
      logic any;
   } cell_ctl_type;

endpackage

### sv/wht_ifs.sv
interface wht_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [wht_pkg::ID_BITS-1:0] window_index;
   logic [wht_pkg::X_BITS-1:0]  rect_left;
   logic [wht_pkg::Y_BITS-1:0]  rect_bottom;
   logic [wht_pkg::X_BITS-1:0]  rect_right;
   logic [wht_pkg::Y_BITS-1:0]  rect_top;
   logic [wht_pkg::X_BITS-1:0]  point_x;
   logic [wht_pkg::Y_BITS-1:0]  point_y;

   modport source (
      output valid, command, window_index, rect_left, rect_bottom, rect_right, rect_top,
             point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, command, window_index, rect_left, rect_bottom, rect_right, rect_top,
             point_x, point_y,
      output ready
   );
endinterface

interface wht_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic [wht_pkg::ID_BITS-1:0] selected_window;

   modport source (output valid, hit, selected_window, input ready);
   modport sink (input valid, hit, selected_window, output ready);
endinterface

### sv/window_hit_test_move_to_front_top.sv
// Window stack with hit test and raise. Each stacking slot is a cell holding a window id and
// its rectangle, slot 0 on top. A load places the window on top (a reload lifts it out of its
// old slot); a click answers with the topmost window that holds the point, edges included,
// and raises it, or a miss. Every transaction that reaches the stack is handled in order: its
// operands are compared against all cells in parallel as it is accepted, then the topmost match
// is resolved along the cell chain and the slots shift; a click also waits at that step while
// the previous result is still not taken. Loads give no result, and a load of an index not below
// WINDOWS is dropped at the accepting edge.
module window_hit_test_move_to_front_top #(
   parameter int WINDOWS = wht_pkg::WINDOWS_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   wht_req_if.sink   req_ch,
   wht_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                        accept;
   logic                        take;
   logic                        capture;
   logic                        out_free;
   logic                        advance;
   wht_pkg::op_type             op_now;
   wht_pkg::cell_ctl_type       ctl;

   logic                        cmd_ff;
   logic [wht_pkg::ID_BITS-1:0] idx_ff;
   wht_pkg::rect_type           rect_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        hit_ff;
   logic [wht_pkg::ID_BITS-1:0] sel_ff;

   logic [WINDOWS:0]            above;
   logic [WINDOWS-1:0]          pick;
   wht_pkg::entry_type          entry_q [WINDOWS];
   wht_pkg::entry_type          top_entry;
   wht_pkg::entry_type          sel_entry;
   logic [$bits(wht_pkg::entry_type)-1:0] sel_bits;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign take = (req_ch.command == wht_pkg::CMD_CLICK)
                 || (32'(req_ch.window_index) < WINDOWS);
   assign capture = accept && take;

   assign op_now = '{command: req_ch.command, idx: req_ch.window_index,
                     x: req_ch.point_x, y: req_ch.point_y};

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance = (state_ff == S_BUSY) && ((cmd_ff == wht_pkg::CMD_LOAD) || out_free);

   assign ctl = '{advance: advance, load: (cmd_ff == wht_pkg::CMD_LOAD), any: above[WINDOWS]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (capture) state_in = S_BUSY;
         S_BUSY: if (advance) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (advance && (cmd_ff == wht_pkg::CMD_CLICK)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         cmd_ff  <= req_ch.command;
         idx_ff  <= req_ch.window_index;
         rect_ff <= '{left: req_ch.rect_left, bottom: req_ch.rect_bottom,
                      right: req_ch.rect_right, top: req_ch.rect_top};
      end
      if (advance && (cmd_ff == wht_pkg::CMD_CLICK)) begin
         hit_ff <= above[WINDOWS];
         sel_ff <= above[WINDOWS] ? sel_entry.id : '0;
      end
   end

   // gather the topmost matching slot; at most one pick bit is set
   always_comb begin
      sel_bits = '0;
      for (int k = 0; k < WINDOWS; k++) begin
         sel_bits = sel_bits | (pick[k] ? entry_q[k] : '0);
      end
   end
   assign sel_entry = wht_pkg::entry_type'(sel_bits);

   assign top_entry = (cmd_ff == wht_pkg::CMD_LOAD)
                      ? '{valid: 1'b1, id: idx_ff, rect: rect_ff}
                      : sel_entry;

   assign above[0] = 1'b0;

   for (genvar k = 0; k < WINDOWS; k++) begin : g_cell
      wht_pkg::entry_type prev;
      if (k == 0) begin : g_head
         assign prev = top_entry;
      end else begin : g_body
         assign prev = entry_q[k-1];
      end
      wht_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .capture    (capture),
         .op         (op_now),
         .ctl        (ctl),
         .above_in   (above[k]),
         .prev_entry (prev),
         .above_out  (above[k+1]),
         .pick       (pick[k]),
         .entry      (entry_q[k])
      );
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hit = hit_ff;
   assign rsp_ch.selected_window = sel_ff;

endmodule

### sv/wht_cell.sv
module wht_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  capture,
   input  wht_pkg::op_type       op,
   input  wht_pkg::cell_ctl_type ctl,
   input  logic                  above_in,
   input  wht_pkg::entry_type    prev_entry,
   output logic                  above_out,
   output logic                  pick,
   output wht_pkg::entry_type    entry
);

   logic                        valid_ff, valid_in;
   logic                        match_ff, match_in;
   logic [wht_pkg::ID_BITS-1:0] id_ff;
   wht_pkg::rect_type           rect_ff;
   logic                        same_id;
   logic                        holds;
   logic                        shift;

   assign same_id = valid_ff && (id_ff == op.idx);
   assign holds = valid_ff
                  && (rect_ff.left <= op.x) && (op.x <= rect_ff.right)
                  && (rect_ff.bottom <= op.y) && (op.y <= rect_ff.top);

   always_comb begin
      if (capture) begin
         match_in = (op.command == wht_pkg::CMD_LOAD) ? same_id : holds;
      end else begin
         match_in = match_ff;
      end
   end

   // take the neighbor's slot at and above the removed position; a push moves everything
   assign shift = ctl.advance && !above_in && (ctl.load || ctl.any);
   assign valid_in = shift ? prev_entry.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         id_ff   <= prev_entry.id;
         rect_ff <= prev_entry.rect;
      end
   end

   assign pick = match_ff && !above_in;
   assign above_out = above_in || match_ff;
   assign entry = '{valid: valid_ff, id: id_ff, rect: rect_ff};

endmodule

### verif/window_hit_test_move_to_front_top_checker.sv
module window_hit_test_move_to_front_top_checker
   import wht_pkg::*;
#(
   parameter int WINDOWS = WINDOWS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   wht_req_if   req_mon,
   wht_rsp_if   rsp_mon,
   output int   failures,
   output int   clicks_pending
);

   typedef struct packed {
      logic               hit;
      logic [ID_BITS-1:0] selected_window;
   } pick_type;

   rect_type           window_rect [WINDOWS];
   logic [ID_BITS-1:0] stack_id [WINDOWS];   // entry 0 is the bottom of the stack
   int unsigned        stack_depth = 0;
   pick_type           expected_picks [$];
   pick_type           want_pick;
   rect_type           loaded_rect;
   int                 mismatches = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // lift the window at stack position pos out and put it on top
   function automatic void raise_slot(int unsigned pos);
      logic [ID_BITS-1:0] id;
      id = stack_id[pos];
      for (int unsigned k = pos; k + 1 < stack_depth; k++) begin
         stack_id[k] = stack_id[k + 1];
      end
      stack_id[stack_depth - 1] = id;
   endfunction

   function automatic bit covers(rect_type r, logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y);
      return r.left <= x && x <= r.right && r.bottom <= y && y <= r.top;
   endfunction

   function automatic void apply_load(logic [ID_BITS-1:0] idx, rect_type r);
      if (idx >= WINDOWS) begin
         return;
      end
      window_rect[idx] = r;
      for (int unsigned k = 0; k < stack_depth; k++) begin
         if (stack_id[k] == idx) begin
            raise_slot(k);
            return;
         end
      end
      if (stack_depth < WINDOWS) begin
         stack_id[stack_depth] = idx;
         stack_depth++;
      end
   endfunction

   function automatic pick_type predict_click(logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y);
      pick_type pick;
      pick = '0;
      for (int k = int'(stack_depth) - 1; k >= 0; k--) begin
         if (covers(window_rect[stack_id[k]], x, y)) begin
            pick.hit = 1'b1;
            pick.selected_window = stack_id[k];
            raise_slot(k);
            break;
         end
      end
      return pick;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stack_depth = 0;
         expected_picks.delete();
      end else begin
         // retire the result first: a click taken at this edge cannot answer yet
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_picks.size() == 0) begin
               report_mismatch($sformatf("result hit=%0b window=%0d with no click waiting",
                                         rsp_mon.hit, rsp_mon.selected_window));
            end else begin
               want_pick = expected_picks.pop_front();
               if (rsp_mon.hit !== want_pick.hit) begin
                  report_mismatch($sformatf("hit got %0b want %0b",
                                            rsp_mon.hit, want_pick.hit));
               end
               if (rsp_mon.selected_window !== want_pick.selected_window) begin
                  report_mismatch($sformatf("selected_window got %0d want %0d",
                                            rsp_mon.selected_window,
                                            want_pick.selected_window));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == CMD_LOAD) begin
               loaded_rect.left   = req_mon.rect_left;
               loaded_rect.bottom = req_mon.rect_bottom;
               loaded_rect.right  = req_mon.rect_right;
               loaded_rect.top    = req_mon.rect_top;
               apply_load(req_mon.window_index, loaded_rect);
            end else begin
               expected_picks.push_back(predict_click(req_mon.point_x, req_mon.point_y));
            end
         end
      end
      failures <= mismatches;
      clicks_pending <= expected_picks.size();
   end

endmodule

### verif/window_hit_test_move_to_front_top_test.sv
module window_hit_test_move_to_front_top_test;
   import wht_pkg::*;

   localparam int WINDOWS      = WINDOWS_DEFAULT;
   localparam int X_MAX        = (1 << X_BITS) - 1;
   localparam int Y_MAX        = (1 << Y_BITS) - 1;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   clicks_pending;
   int   items_sent = 0;
   int   cycle_count = 0;
   logic steady_flow = 1'b0;   // no idling on either side
   logic hold_rsp = 1'b0;

   // what was loaded where, only to aim clicks at live windows
   rect_type placed_rect [WINDOWS];
   logic     placed [WINDOWS];

   wht_req_if req_ch ();
   wht_rsp_if rsp_ch ();

   window_hit_test_move_to_front_top #(.WINDOWS(WINDOWS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   window_hit_test_move_to_front_top_checker #(.WINDOWS(WINDOWS)) pick_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .failures       (failures),
      .clicks_pending (clicks_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_flow || $urandom_range(99) >= 19;
      end
   end

   // back-pressure: stall the result side long enough to fill the block
   initial begin
      wait (items_sent >= 500);
      hold_rsp <= 1'b1;
      for (int c = 0; c < HOLD_CYCLES; c++) begin
         @(posedge clock);
      end
      hold_rsp <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("window_hit_test_move_to_front_top test failed");
      $finish;
   end

   task automatic send(input logic cmd, input logic [ID_BITS-1:0] idx, input rect_type r,
                       input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y);
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.window_index <= idx;
      req_ch.rect_left    <= r.left;
      req_ch.rect_bottom  <= r.bottom;
      req_ch.rect_right   <= r.right;
      req_ch.rect_top     <= r.top;
      req_ch.point_x      <= x;
      req_ch.point_y      <= y;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      items_sent++;
   endtask

   function automatic rect_type make_rect();
      rect_type r;
      int lx;
      int ly;
      r.left   = X_BITS'($urandom);
      r.bottom = Y_BITS'($urandom);
      r.right  = X_BITS'($urandom);
      r.top    = Y_BITS'($urandom);
      case ($urandom_range(9))
         0: begin
            // inverted in x
            r.left  = X_BITS'($urandom_range(X_MAX, 1));
            r.right = X_BITS'($urandom_range(r.left - 1));
         end
         1: begin
            // inverted in y
            r.bottom = Y_BITS'($urandom_range(Y_MAX, 1));
            r.top    = Y_BITS'($urandom_range(r.bottom - 1));
         end
         2: begin
         end
         default: begin
            lx = $urandom_range(X_MAX);
            ly = $urandom_range(Y_MAX);
            r.left   = X_BITS'(lx);
            r.bottom = Y_BITS'(ly);
            r.right  = (lx + 800 > X_MAX) ? X_BITS'($urandom_range(X_MAX, lx))
                                          : X_BITS'($urandom_range(lx + 800, lx));
            r.top    = (ly + 500 > Y_MAX) ? Y_BITS'($urandom_range(Y_MAX, ly))
                                          : Y_BITS'($urandom_range(ly + 500, ly));
         end
      endcase
      return r;
   endfunction

   task automatic load_rect(input logic [ID_BITS-1:0] idx, input rect_type r);
      placed_rect[idx] = r;
      placed[idx] = 1'b1;
      send(CMD_LOAD, idx, r, X_BITS'($urandom), Y_BITS'($urandom));
   endtask

   task automatic load(input logic [ID_BITS-1:0] idx, input int l, input int b,
                       input int rt, input int t);
      rect_type r;
      r.left   = X_BITS'(l);
      r.bottom = Y_BITS'(b);
      r.right  = X_BITS'(rt);
      r.top    = Y_BITS'(t);
      load_rect(idx, r);
   endtask

   // window index and rectangle ride along as noise; the block ignores them
   task automatic click(input int x, input int y);
      send(CMD_CLICK, ID_BITS'($urandom), make_rect(), X_BITS'(x), Y_BITS'(y));
   endtask

   task automatic random_click();
      int i;
      int x;
      int y;
      rect_type r;
      x = $urandom_range(X_MAX);
      y = $urandom_range(Y_MAX);
      if ($urandom_range(9) < 7) begin
         i = $urandom_range(WINDOWS - 1);
         while (!placed[i]) begin
            i = (i + 1) % WINDOWS;
         end
         r = placed_rect[i];
         if (r.left <= r.right && r.bottom <= r.top) begin
            x = $urandom_range(r.right, r.left);
            y = $urandom_range(r.top, r.bottom);
            if ($urandom_range(3) == 0) begin
               x = $urandom_range(1) ? int'(r.left) : int'(r.right);
            end
            if ($urandom_range(3) == 0) begin
               y = $urandom_range(1) ? int'(r.bottom) : int'(r.top);
            end
         end
      end
      click(x, y);
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_LOAD;
      req_ch.window_index = '0;
      req_ch.rect_left    = '0;
      req_ch.rect_bottom  = '0;
      req_ch.rect_right   = '0;
      req_ch.rect_top     = '0;
      req_ch.point_x      = '0;
      req_ch.point_y      = '0;
      rsp_ch.ready        = 1'b0;
      for (int i = 0; i < WINDOWS; i++) begin
         placed[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty stack answers a miss
      click(100, 100);
      // full screen window, hit at both far corners
      load(0, 0, 0, X_MAX, Y_MAX);
      click(0, 0);
      click(X_MAX, Y_MAX);
      // edges are inclusive, one past an edge falls through to the window below
      load(5, 100, 200, 300, 400);
      click(100, 200);
      click(300, 400);
      click(301, 400);
      click(100, 199);
      click(200, 300);
      // inverted rectangles take a place on the stack but never catch a click
      load(9, 500, 10, 400, 20);
      load(10, 400, 20, 500, 10);
      click(450, 15);
      // reload: new rectangle, raised to the top
      load(5, 0, 0, 0, 0);
      click(0, 0);
      click(200, 300);
      load(15, X_MAX, Y_MAX, X_MAX, Y_MAX);
      click(X_MAX, Y_MAX);
      click(X_MAX - 1, Y_MAX);
      load(3, 1000, 1000, 1000, 1000);
      click(1000, 1000);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady_flow <= (n >= 300 && n < 420);
         if ($urandom_range(99) < 40) begin
            load_rect(ID_BITS'($urandom), make_rect());
         end else begin
            random_click();
         end
      end
      req_ch.valid <= 1'b0;
      steady_flow <= 1'b0;

      @(posedge clock);
      while (clicks_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("window_hit_test_move_to_front_top test passed");
      end else begin
         $display("window_hit_test_move_to_front_top test failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/wht_pkg.sv
sv/wht_ifs.sv
sv/wht_cell.sv
sv/window_hit_test_move_to_front_top.sv
verif/window_hit_test_move_to_front_top_checker.sv
verif/window_hit_test_move_to_front_top_test.sv
